### rtl/sss_pkg.sv
// Shared types and constants of the sparse-set component store.
package sss_pkg;

    // Sizes of the slot space and the dense array
    localparam int SLOT_COUNT     = 1024;
    localparam int SLOT_W         = $clog2(SLOT_COUNT);
    localparam int ENTRY_CAPACITY = 1024;
    localparam int POS_W          = $clog2(ENTRY_CAPACITY);
    localparam int COUNT_W        = POS_W + 1;
    localparam int GEN_W          = 16;
    localparam int VAL_W          = 32;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_FULL      = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    // One input item
    typedef struct packed {
        t_op                     operation;
        logic [SLOT_W-1:0]       entity_slot;
        logic [GEN_W-1:0]        key_generation;
        logic signed [VAL_W-1:0] new_width;
        logic signed [VAL_W-1:0] new_height;
        logic [POS_W-1:0]        dense_position;
    } t_in_item;

    // One result item
    typedef struct packed {
        t_status                 status;
        logic [POS_W-1:0]        found_position;
        logic [SLOT_W-1:0]       owner_slot;
        logic signed [VAL_W-1:0] out_width;
        logic signed [VAL_W-1:0] out_height;
        logic [COUNT_W-1:0]      entry_count;
    } t_result;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              accept;
        logic              exec;
        logic              fetch;
        logic              clear;
        logic [SLOT_W-1:0] clear_addr;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic lookup_hit;
    } t_stat;

endpackage

### rtl/sss_ctrl.sv
// Controller state machine of the sparse-set component store.
module sss_ctrl
    import sss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_FETCH = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_clr_addr;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == SLOT_W'(SLOT_COUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.lookup_hit ? S_FETCH : S_IDLE;
            end
            S_FETCH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and sweep the valid marks after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Drive commands
    assign busy             = (r_state != S_IDLE);
    assign o_cmd.accept     = (r_state == S_IDLE) && start;
    assign o_cmd.exec       = (r_state == S_EXEC);
    assign o_cmd.fetch      = (r_state == S_FETCH);
    assign o_cmd.clear      = (r_state == S_CLEAR);
    assign o_cmd.clear_addr = r_clr_addr;

endmodule

### rtl/sss_dpath.sv
// Datapath of the sparse-set component store: slot maps, dense array and result register.
module sss_dpath
    import sss_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_item i_item,
    input  t_cmd     i_cmd,
    output t_stat    o_stat,
    output logic     o_done,
    output t_result  o_result
);

    typedef struct packed {
        logic             valid;
        logic [GEN_W-1:0] gen;
    } t_vg;

    typedef struct packed {
        logic [SLOT_W-1:0]       owner;
        logic signed [VAL_W-1:0] w;
        logic signed [VAL_W-1:0] h;
    } t_dense;

    // Memories
    t_vg              r_vg_mem    [SLOT_COUNT];
    logic [POS_W-1:0] r_pos_mem   [SLOT_COUNT];
    t_dense           r_dense_mem [ENTRY_CAPACITY];

    t_in_item           r_item;
    t_vg                r_vg_q;
    logic [POS_W-1:0]   r_pos_q;
    t_dense             r_dense_q;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_done;
    t_result            r_result;

    t_result           n_result;
    logic              respond, hit;
    logic              gen_match, key_ok;
    logic [POS_W-1:0]  last;
    logic              vg_we, pos_we, dense_we, dense_re;
    logic [SLOT_W-1:0] vg_waddr, pos_waddr;
    t_vg               vg_wdata;
    logic [POS_W-1:0]  pos_wdata, dense_waddr, dense_raddr;
    t_dense            dense_wdata;

    // Key checks on the read data
    assign gen_match = r_vg_q.valid && (r_vg_q.gen == r_item.key_generation);
    assign key_ok    = gen_match && ({1'b0, r_pos_q} < r_count);
    assign last      = POS_W'(r_count - 1'b1);

    // Dense read: last entry or read position on accept, looked-up position on a hit
    assign dense_re    = i_cmd.accept || (i_cmd.exec && hit);
    assign dense_raddr = i_cmd.accept
                       ? ((i_item.operation == OP_READ) ? i_item.dense_position
                                                        : POS_W'(r_count - 1'b1))
                       : r_pos_q;

    // Decide the operation and its writes
    always_comb begin
        n_count     = r_count;
        hit         = 1'b0;
        vg_we       = 1'b0;
        vg_waddr    = r_item.entity_slot;
        vg_wdata    = '0;
        pos_we      = 1'b0;
        pos_waddr   = r_item.entity_slot;
        pos_wdata   = POS_W'(r_count);
        dense_we    = 1'b0;
        dense_waddr = POS_W'(r_count);
        dense_wdata = '{owner: r_item.entity_slot, w: r_item.new_width, h: r_item.new_height};
        n_result    = '0;
        if (i_cmd.clear) begin
            vg_we    = 1'b1;
            vg_waddr = i_cmd.clear_addr;
        end else if (i_cmd.exec) begin
            unique case (r_item.operation)
                OP_ADD: begin
                    if (gen_match) begin
                        n_result.status = ST_PRESENT;
                    end else if (r_count == COUNT_W'(ENTRY_CAPACITY)) begin
                        n_result.status = ST_FULL;
                    end else begin
                        vg_we                   = 1'b1;
                        vg_wdata                = '{valid: 1'b1, gen: r_item.key_generation};
                        pos_we                  = 1'b1;
                        dense_we                = 1'b1;
                        n_count                 = r_count + 1'b1;
                        n_result.status         = ST_OK;
                        n_result.found_position = POS_W'(r_count);
                        n_result.out_width      = r_item.new_width;
                        n_result.out_height     = r_item.new_height;
                    end
                end
                OP_REMOVE: begin
                    if (!key_ok) begin
                        n_result.status = ST_NOT_FOUND;
                    end else begin
                        // swap the last entry into the freed position
                        if (r_pos_q < last) begin
                            dense_we    = 1'b1;
                            dense_waddr = r_pos_q;
                            dense_wdata = r_dense_q;
                            pos_we      = 1'b1;
                            pos_waddr   = r_dense_q.owner;
                            pos_wdata   = r_pos_q;
                        end
                        vg_we           = 1'b1;
                        vg_wdata        = '{valid: 1'b0, gen: r_vg_q.gen};
                        n_count         = r_count - 1'b1;
                        n_result.status = ST_OK;
                    end
                end
                OP_LOOKUP: begin
                    if (!key_ok) n_result.status = ST_NOT_FOUND;
                    else         hit             = 1'b1;
                end
                OP_READ: begin
                    if ({1'b0, r_item.dense_position} < r_count) begin
                        n_result.status     = ST_OK;
                        n_result.owner_slot = r_dense_q.owner;
                        n_result.out_width  = r_dense_q.w;
                        n_result.out_height = r_dense_q.h;
                    end else begin
                        n_result.status = ST_RANGE;
                    end
                end
                default: begin
                    n_result.status = ST_OK;
                end
            endcase
        end else if (i_cmd.fetch) begin
            n_result.status         = ST_OK;
            n_result.found_position = r_pos_q;
            n_result.out_width      = r_dense_q.w;
            n_result.out_height     = r_dense_q.h;
        end
        n_result.entry_count = n_count;
    end

    assign respond           = (i_cmd.exec && !hit) || i_cmd.fetch;
    assign o_stat.lookup_hit = hit;

    // Slot memories: write, and read on accept
    always_ff @(posedge i_clk) begin
        if (vg_we)  r_vg_mem[vg_waddr]   <= vg_wdata;
        if (pos_we) r_pos_mem[pos_waddr] <= pos_wdata;
        if (i_cmd.accept) begin
            r_vg_q  <= r_vg_mem[i_item.entity_slot];
            r_pos_q <= r_pos_mem[i_item.entity_slot];
        end
    end

    // Dense memory: write and registered read
    always_ff @(posedge i_clk) begin
        if (dense_we) r_dense_mem[dense_waddr] <= dense_wdata;
        if (dense_re) r_dense_q <= r_dense_mem[dense_raddr];
    end

    // Capture the item and the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_item <= i_item;
        if (respond)      r_result <= n_result;
    end

    // Hold count and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= respond;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // Result strobes never come back to back
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobes in consecutive cycles");

    // No result in the cycle after an item is taken
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |=> !r_done)
        else $error("result strobe right after accept");

    // Count moves only while an item executes
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_count))
        else $error("entry count changed outside execution");

    // Count never passes the capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(ENTRY_CAPACITY))
        else $error("entry count beyond capacity");

endmodule

### rtl/sparse_set_component_store.sv
// Top level of the sparse-set component store: controller and datapath.
//
//  channel   ports                     handshake
//  --------  ------------------------  -------------------------------------
//  item in   i_item (t_in_item)        taken when start is high, busy low
//  result    o_result (t_result)       valid for one cycle while o_done high
//
// Add, remove, read by position and a missed lookup go from accept through
// execution back to idle; a lookup that hits adds a fetch, as its dense
// read depends on the slot map read. The result appears in the cycle after
// execution; a new item may be taken in that same cycle. After reset busy
// stays high while the slot valid marks are swept clear, one slot a cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sparse_set_component_store
    import sss_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_in_item i_item,
    output logic     busy,
    output logic     o_done,
    output t_result  o_result
);

    t_cmd  cmd;
    t_stat stat;

    // Sequence the operation
    sss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Hold the maps and produce the result
    sss_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

### tb/sparse_set_component_store_tb.sv
// Self-checking testbench of the sparse-set component store: table-driven and random items.
module sparse_set_component_store_tb;
    import sss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 2;
    localparam int V_MIN       = 32'h8000_0000;
    localparam int V_MAX       = 32'h7FFF_FFFF;
    localparam int MIXED_ITEMS = 250;
    localparam int DRAIN_ITEMS = 250;
    localparam int TAIL_ITEMS  = 100;
    localparam int FULL_ADDS   = 6;

    // Shapes of random traffic
    typedef enum int {
        PH_MIXED,
        PH_FILL,
        PH_DRAIN
    } t_phase;

    // One row of the directed table; res is used only when typed is set
    typedef struct {
        t_in_item item;
        bit       typed;
        t_result  res;
    } t_stim_row;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_in_item i_item  = '0;
    logic     busy;
    logic     o_done;
    t_result  o_result;

    // Predicted contents of the store
    bit [POS_W-1:0]        pos_of_slot   [SLOT_COUNT];
    bit [GEN_W-1:0]        gen_of_slot   [SLOT_COUNT];
    bit                    live_slot     [SLOT_COUNT];
    bit [SLOT_W-1:0]       slot_at_pos   [ENTRY_CAPACITY];
    bit signed [VAL_W-1:0] width_at_pos  [ENTRY_CAPACITY];
    bit signed [VAL_W-1:0] height_at_pos [ENTRY_CAPACITY];
    int                    live_count;

    t_result   pending_results[$];
    t_stim_row directed_rows[$];
    int        error_count;
    int        burst_left;

    sparse_set_component_store DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Apply one item to the predicted store and return its result
    function automatic t_result apply_operation(t_in_item it);
        t_result         r;
        int              p;
        int              last;
        bit              hit;
        bit [SLOT_W-1:0] s;
        bit [SLOT_W-1:0] moved;
        r = '0;
        r.status = ST_OK;
        s = it.entity_slot;
        p = pos_of_slot[s];
        // a key is live only when marked, of the same generation and inside the array
        hit = live_slot[s] && gen_of_slot[s] == it.key_generation && p < live_count;
        case (it.operation)
            OP_ADD: begin
                if (live_slot[s] && gen_of_slot[s] == it.key_generation) begin
                    r.status = ST_PRESENT;
                end else if (live_count >= ENTRY_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // append; a stale slot is simply repointed, its old entry stays
                    p = live_count;
                    width_at_pos[p]  = it.new_width;
                    height_at_pos[p] = it.new_height;
                    slot_at_pos[p]   = s;
                    pos_of_slot[s]   = POS_W'(p);
                    gen_of_slot[s]   = it.key_generation;
                    live_slot[s]     = 1'b1;
                    live_count++;
                    r.found_position = POS_W'(p);
                    r.out_width      = it.new_width;
                    r.out_height     = it.new_height;
                end
            end
            OP_REMOVE: begin
                if (!hit) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    // swap the last entry into the hole, then pop
                    last = live_count - 1;
                    if (p < last) begin
                        moved              = slot_at_pos[last];
                        width_at_pos[p]    = width_at_pos[last];
                        height_at_pos[p]   = height_at_pos[last];
                        pos_of_slot[moved] = POS_W'(p);
                        slot_at_pos[p]     = moved;
                    end
                    live_slot[s] = 1'b0;
                    live_count   = last;
                end
            end
            OP_LOOKUP: begin
                if (!hit) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.found_position = POS_W'(p);
                    r.out_width      = width_at_pos[p];
                    r.out_height     = height_at_pos[p];
                end
            end
            default: begin
                p = it.dense_position;
                if (p >= live_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.owner_slot = slot_at_pos[p];
                    r.out_width  = width_at_pos[p];
                    r.out_height = height_at_pos[p];
                end
            end
        endcase
        r.entry_count = COUNT_W'(live_count);
        return r;
    endfunction

    function automatic t_in_item mk_item(t_op op, int slot, int gen, int w, int h, int pos);
        t_in_item it;
        it.operation      = op;
        it.entity_slot    = SLOT_W'(slot);
        it.key_generation = GEN_W'(gen);
        it.new_width      = w;
        it.new_height     = h;
        it.dense_position = POS_W'(pos);
        return it;
    endfunction

    function automatic t_result mk_res(t_status st, int fpos, int owner, int w, int h, int cnt);
        t_result r;
        r.status         = st;
        r.found_position = POS_W'(fpos);
        r.owner_slot     = SLOT_W'(owner);
        r.out_width      = w;
        r.out_height     = h;
        r.entry_count    = COUNT_W'(cnt);
        return r;
    endfunction

    // Draw one random item shaped by the phase
    function automatic t_in_item pick_item(t_phase ph);
        t_in_item it;
        int       roll;
        int       s;
        it.entity_slot    = SLOT_W'($urandom);
        it.key_generation = GEN_W'($urandom);
        it.new_width      = $urandom;
        it.new_height     = $urandom;
        it.dense_position = POS_W'($urandom);
        it.operation      = t_op'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        case (ph)
            PH_MIXED: begin
                // small pool of slots at both ends of the range, so keys collide
                s = $urandom_range(0, 15);
                it.entity_slot = SLOT_W'((s < 8) ? s : SLOT_COUNT - 16 + s);
                if (roll < 35)      it.operation = OP_ADD;
                else if (roll < 60) it.operation = OP_REMOVE;
                else if (roll < 80) it.operation = OP_LOOKUP;
                else                it.operation = OP_READ;
                if ($urandom_range(0, 9) < 7) begin
                    it.key_generation = gen_of_slot[it.entity_slot];
                end else begin
                    case ($urandom_range(0, 3))
                        0:       it.key_generation = '0;
                        1:       it.key_generation = GEN_W'(1);
                        2:       it.key_generation = '1;
                        default: it.key_generation = gen_of_slot[it.entity_slot] + 1'b1;
                    endcase
                end
                if ($urandom_range(0, 7) == 0) it.new_width  = V_MIN;
                if ($urandom_range(0, 7) == 0) it.new_height = V_MAX;
                if ($urandom_range(0, 4) != 0)
                    it.dense_position = POS_W'($urandom_range(0, live_count));
            end
            PH_FILL: begin
                if (roll < 92) it.operation = OP_ADD;
            end
            default: begin
                // aim at keys that own entries, mostly with their own generation
                if (live_count > 0) begin
                    it.entity_slot = slot_at_pos[$urandom_range(0, live_count - 1)];
                    if ($urandom_range(0, 4) != 0)
                        it.key_generation = gen_of_slot[it.entity_slot];
                end
                if (roll < 55)      it.operation = OP_REMOVE;
                else if (roll < 75) it.operation = OP_LOOKUP;
                else if (roll < 90) it.operation = OP_READ;
                else                it.operation = OP_ADD;
                if ($urandom_range(0, 3) != 0)
                    it.dense_position = POS_W'($urandom_range(0, live_count));
            end
        endcase
        return it;
    endfunction

    // End a burst now and then and hold start low for a random gap
    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Offer one item, wait for it to be taken, and queue what it should give
    task automatic send_item(t_in_item it, bit typed, t_result typed_res);
        t_result predicted;
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = apply_operation(it);
        pending_results.push_back(typed ? typed_res : predicted);
        pace();
    endtask

    // Hold off until every queued result has come back
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(t_phase ph, int n);
        for (int i = 0; i < n; i++) send_item(pick_item(ph), 1'b0, '0);
    endtask

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("o_result: no result expected, got status %0d", o_result.status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    error_count++;
                end
                if (o_result.found_position !== want.found_position) begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_position, o_result.found_position);
                    error_count++;
                end
                if (o_result.owner_slot !== want.owner_slot) begin
                    $error("owner_slot: expected %0d, got %0d",
                           want.owner_slot, o_result.owner_slot);
                    error_count++;
                end
                if (o_result.out_width !== want.out_width) begin
                    $error("out_width: expected %0d, got %0d",
                           want.out_width, o_result.out_width);
                    error_count++;
                end
                if (o_result.out_height !== want.out_height) begin
                    $error("out_height: expected %0d, got %0d",
                           want.out_height, o_result.out_height);
                    error_count++;
                end
                if (o_result.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, o_result.entry_count);
                    error_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        error_count = 0;
        live_count  = 0;
        burst_left  = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store: misses and out-of-range reads
        directed_rows.push_back('{mk_item(OP_LOOKUP, 0, 0, 0, 0, 0), 1'b1,
                                  mk_res(ST_NOT_FOUND, 0, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_item(OP_REMOVE, 1023, 65535, 0, 0, 0), 1'b1,
                                  mk_res(ST_NOT_FOUND, 0, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_item(OP_READ, 0, 0, 0, 0, 0), 1'b1,
                                  mk_res(ST_RANGE, 0, 0, 0, 0, 0)});
        // extreme keys and values
        directed_rows.push_back('{mk_item(OP_ADD, 0, 0, V_MIN, V_MAX, 0), 1'b1,
                                  mk_res(ST_OK, 0, 0, V_MIN, V_MAX, 1)});
        directed_rows.push_back('{mk_item(OP_ADD, 1023, 65535, V_MAX, V_MIN, 1023), 1'b1,
                                  mk_res(ST_OK, 1, 0, V_MAX, V_MIN, 2)});
        // same key added twice
        directed_rows.push_back('{mk_item(OP_ADD, 0, 0, 5, 5, 0), 1'b1,
                                  mk_res(ST_PRESENT, 0, 0, 0, 0, 2)});
        directed_rows.push_back('{mk_item(OP_LOOKUP, 1023, 65535, 0, 0, 0), 1'b1,
                                  mk_res(ST_OK, 1, 0, V_MAX, V_MIN, 2)});
        // wrong generation
        directed_rows.push_back('{mk_item(OP_LOOKUP, 1023, 65534, 0, 0, 0), 1'b1,
                                  mk_res(ST_NOT_FOUND, 0, 0, 0, 0, 2)});
        directed_rows.push_back('{mk_item(OP_READ, 0, 0, 0, 0, 1), 1'b1,
                                  mk_res(ST_OK, 0, 1023, V_MAX, V_MIN, 2)});
        directed_rows.push_back('{mk_item(OP_READ, 0, 0, 0, 0, 1023), 1'b1,
                                  mk_res(ST_RANGE, 0, 0, 0, 0, 2)});
        directed_rows.push_back('{mk_item(OP_ADD, 5, 7, -1, 0, 0), 1'b0, '0});
        // stale slot overwritten by a new generation, old entry left behind
        directed_rows.push_back('{mk_item(OP_ADD, 0, 1, 123, 456, 0), 1'b0, '0});
        directed_rows.push_back('{mk_item(OP_LOOKUP, 0, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_item(OP_READ, 0, 0, 0, 0, 0), 1'b0, '0});
        // remove from the middle moves the last entry down
        directed_rows.push_back('{mk_item(OP_REMOVE, 1023, 65535, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_item(OP_LOOKUP, 0, 1, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_item(OP_REMOVE, 0, 1, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_item(OP_READ, 0, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_item(OP_LOOKUP, 5, 7, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_item(OP_REMOVE, 5, 7, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_item(OP_REMOVE, 5, 7, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_item(OP_READ, 0, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_item(OP_ADD, 0, 1, V_MAX, V_MAX, 0), 1'b0, '0});
        directed_rows.push_back('{mk_item(OP_LOOKUP, 0, 1, 0, 0, 0), 1'b0, '0});
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
        wait_idle();

        // colliding keys on a small pool
        run_phase(PH_MIXED, MIXED_ITEMS);
        wait_idle();

        // fill the array to capacity, then knock on the full store
        while (live_count < ENTRY_CAPACITY) send_item(pick_item(PH_FILL), 1'b0, '0);
        for (int i = 0; i < FULL_ADDS; i++)
            send_item(mk_item(OP_ADD, $urandom, $urandom, $urandom, $urandom,
                              ENTRY_CAPACITY - 1), 1'b0, '0);
        send_item(mk_item(OP_READ, 0, 0, 0, 0, ENTRY_CAPACITY - 1), 1'b0, '0);
        wait_idle();

        // drain part of it with mostly valid removes
        run_phase(PH_DRAIN, DRAIN_ITEMS);
        wait_idle();
        run_phase(PH_MIXED, TAIL_ITEMS);
        wait_idle();

        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
rtl/sss_pkg.sv
rtl/sss_ctrl.sv
rtl/sss_dpath.sv
rtl/sparse_set_component_store.sv
tb/sparse_set_component_store_tb.sv
